@@ src/dcq_pkg.sv @@
// ----------------------------------------------------------------------------
// dcq_pkg
// Shared types and codes for the bounded deque with delete by value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int LENGTH_W = 7;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_PUSH_FRONT,
        CM_PUSH_BACK,
        CM_ROTATE,
        CM_POP
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       at_tail;
        logic       at_back;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/dcq_in_if.sv @@
// ----------------------------------------------------------------------------
// dcq_in_if
// Command channel: one operation word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcq_in_if;
    logic                               valid;
    logic                               ready;
    logic        [dcq_pkg::OP_W-1:0]    op;
    logic signed [dcq_pkg::VALUE_W-1:0] value;
    logic        [dcq_pkg::POS_W-1:0]   position;

    modport source (output valid, op, value, position, input ready);
    modport sink   (input valid, op, value, position, output ready);
endinterface

`default_nettype wire

@@ src/dcq_out_if.sv @@
// ----------------------------------------------------------------------------
// dcq_out_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dcq_out_if;
    logic                                valid;
    logic                                ready;
    logic        [dcq_pkg::STATUS_W-1:0] status;
    logic signed [dcq_pkg::VALUE_W-1:0]  data_out;
    logic        [dcq_pkg::LENGTH_W-1:0] length;

    modport source (output valid, status, data_out, length, input ready);
    modport sink   (input valid, status, data_out, length, output ready);
endinterface

`default_nettype wire

@@ src/dcq_cell.sv @@
// ----------------------------------------------------------------------------
// dcq_cell
// One storage cell of the deque row; takes from its neighbors, the head
// cell or the incoming value as the row command says.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcq_cell (
    input  wire logic                               clk,
    input  wire dcq_pkg::cell_ctrl_t                ctrl,
    input  wire logic signed [dcq_pkg::VALUE_W-1:0] left_data,
    input  wire logic signed [dcq_pkg::VALUE_W-1:0] right_data,
    input  wire logic signed [dcq_pkg::VALUE_W-1:0] head_data,
    input  wire logic signed [dcq_pkg::VALUE_W-1:0] value,
    output      logic signed [dcq_pkg::VALUE_W-1:0] data
);

    logic signed [dcq_pkg::VALUE_W-1:0] entry_reg;
    logic signed [dcq_pkg::VALUE_W-1:0] entry_next;

    always_comb
    begin
        unique case (ctrl.mode)
            dcq_pkg::CM_PUSH_FRONT: entry_next = left_data;
            dcq_pkg::CM_PUSH_BACK:  entry_next = ctrl.at_back ? value : entry_reg;
            dcq_pkg::CM_ROTATE:     entry_next = ctrl.at_tail ? head_data : right_data;
            dcq_pkg::CM_POP:        entry_next = right_data;
            default:                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

`default_nettype wire

@@ src/bounded_deque_with_value_delete_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_unit
// Bounded deque of signed words held in a row of cells in list order,
// with delete first, delete last, delete by value and read at a position.
// ----------------------------------------------------------------------------
//   port   dir   word
//   cmd    in    op, value, position
//   rsp    out   status, data_out, length
//
// inserts, unused codes and empty, full or bad position answers: result is
// registered as the word is taken.
// deletes and reads: the row rotates one place a cycle through the head cell,
// and the result is registered on the last step.
// reset clears control and length only; cells keep no reset value.
// a pending result sits in the output register; the next word is taken in the
// cycle that result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_delete_unit #(
    parameter int CAPACITY = 64
) (
    input wire logic  clk,
    input wire logic  rst_n,
    dcq_in_if.sink    cmd,
    dcq_out_if.source rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > dcq_pkg::POS_W) ? CW : dcq_pkg::POS_W;

    logic signed [dcq_pkg::VALUE_W-1:0] cell_data [CAPACITY];
    dcq_pkg::cell_ctrl_t                cell_ctrl [CAPACITY];
    dcq_pkg::cell_mode_t                mode;
    logic signed [dcq_pkg::VALUE_W-1:0] head;

    dcq_pkg::state_t                     state_reg, state_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [CW-1:0]                       n_reg, n_next;
    logic [CW-1:0]                       step_reg, step_next;
    logic [dcq_pkg::OP_W-1:0]            op_reg, op_next;
    logic signed [dcq_pkg::VALUE_W-1:0]  key_reg, key_next;
    logic [dcq_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic                                taken_reg, taken_next;
    logic signed [dcq_pkg::VALUE_W-1:0]  data_reg, data_next;

    logic                                out_valid_reg, out_valid_next;
    logic [dcq_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [dcq_pkg::VALUE_W-1:0]  out_data_reg, out_data_next;
    logic [dcq_pkg::LENGTH_W-1:0]        out_length_reg, out_length_next;

    logic accept;
    logic last_step;
    logic hit;
    logic take;
    logic drop;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [dcq_pkg::VALUE_W-1:0] left_d;
        logic signed [dcq_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cmd.value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_data[0];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        assign cell_ctrl[i].mode    = mode;
        assign cell_ctrl[i].at_tail = (count_reg == CW'(i + 1));
        assign cell_ctrl[i].at_back = (count_reg == CW'(i));

        dcq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .value      (cmd.value),
            .data       (cell_data[i])
        );
    end

    assign head      = cell_data[0];
    assign cmd.ready = (state_reg == dcq_pkg::S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign last_step = (step_reg == CW'(n_reg - 1'b1));

    always_comb
    begin
        unique case (op_reg)
            dcq_pkg::OP_DEL_FIRST: hit = (step_reg == '0);
            dcq_pkg::OP_DEL_LAST:  hit = last_step;
            dcq_pkg::OP_DEL_VALUE: hit = (head == key_reg);
            dcq_pkg::OP_READ:      hit = (CMPW'(step_reg) == CMPW'(pos_reg));
            default:               hit = 1'b0;
        endcase
    end

    assign take = !taken_reg && hit;
    assign drop = take && (op_reg != dcq_pkg::OP_READ);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        taken_next      = taken_reg;
        data_next       = data_reg;
        mode            = dcq_pkg::CM_HOLD;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_length_next = out_length_reg;

        unique case (state_reg)
            dcq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        dcq_pkg::OP_INS_FRONT, dcq_pkg::OP_INS_BACK:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            if (count_reg == CW'(CAPACITY))
                            begin
                                out_status_next = dcq_pkg::ST_FULL;
                                out_length_next = dcq_pkg::LENGTH_W'(count_reg);
                            end
                            else
                            begin
                                mode            = (cmd.op == dcq_pkg::OP_INS_FRONT) ?
                                                  dcq_pkg::CM_PUSH_FRONT :
                                                  dcq_pkg::CM_PUSH_BACK;
                                count_next      = CW'(count_reg + 1'b1);
                                out_status_next = dcq_pkg::ST_OK;
                                out_length_next = dcq_pkg::LENGTH_W'(count_next);
                            end
                        end
                        dcq_pkg::OP_DEL_FIRST, dcq_pkg::OP_DEL_LAST,
                        dcq_pkg::OP_DEL_VALUE, dcq_pkg::OP_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = dcq_pkg::ST_EMPTY;
                                out_data_next   = '0;
                                out_length_next = dcq_pkg::LENGTH_W'(count_reg);
                            end
                            else if ((cmd.op == dcq_pkg::OP_READ) &&
                                     (CMPW'(cmd.position) >= CMPW'(count_reg)))
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = dcq_pkg::ST_BAD_POS;
                                out_data_next   = '0;
                                out_length_next = dcq_pkg::LENGTH_W'(count_reg);
                            end
                            else
                            begin
                                state_next = dcq_pkg::S_SCAN;
                                op_next    = cmd.op;
                                key_next   = cmd.value;
                                pos_next   = cmd.position;
                                n_next     = count_reg;
                                step_next  = '0;
                                taken_next = 1'b0;
                                data_next  = '0;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = dcq_pkg::ST_OK;
                            out_data_next   = '0;
                            out_length_next = dcq_pkg::LENGTH_W'(count_reg);
                        end
                    endcase
                end
            end
            dcq_pkg::S_SCAN:
            begin
                // entry at the head is list index step_reg; rotate it to the tail
                // or drop it
                mode      = drop ? dcq_pkg::CM_POP : dcq_pkg::CM_ROTATE;
                step_next = CW'(step_reg + 1'b1);
                if (take)
                begin
                    taken_next = 1'b1;
                    data_next  = head;
                end
                if (drop)
                begin
                    count_next = CW'(count_reg - 1'b1);
                end
                if (last_step)
                begin
                    state_next      = dcq_pkg::S_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = (taken_reg || take) ? dcq_pkg::ST_OK :
                                                            dcq_pkg::ST_NOT_FOUND;
                    out_data_next   = take ? head : data_reg;
                    out_length_next = dcq_pkg::LENGTH_W'(count_next);
                end
            end
            default:
            begin
                state_next = dcq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcq_pkg::S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            n_reg         <= '0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        data_reg       <= data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_length_reg <= out_length_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.data_out = out_data_reg;
    assign rsp.length   = out_length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcq_pkg::S_SCAN) |-> (step_reg < n_reg))
        else $error("scan step past list length");

    a_scan_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcq_pkg::S_SCAN) |-> !out_valid_reg)
        else $error("result pending during scan");

endmodule

`default_nettype wire
